// File: src/dmc_pkg.sv
// shared types, constants and helper functions of the depth-first maze carver
package dmc_pkg;

    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 32;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 5;
    localparam int PICK_W    = 4;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int WALL_W    = 4;
    localparam int CELL_W    = WALL_W + 1;
    localparam int VIS_BIT   = WALL_W;

    localparam logic [CFG_W-1:0] COLS_RST = 6'd32;
    localparam logic [CFG_W-1:0] ROWS_RST = 6'd32;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

    // direction codes as seen from the current cell
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // neighbour scan order
    localparam logic [1:0] NB_S = 2'd0;
    localparam logic [1:0] NB_E = 2'd1;
    localparam logic [1:0] NB_N = 2'd2;
    localparam logic [1:0] NB_W = 2'd3;

    localparam logic [WALL_W-1:0] ALL_WALLS = 4'hF;
    localparam logic [CELL_W-1:0] CLR_CELL  = {1'b0, ALL_WALLS};
    localparam logic [CELL_W-1:0] START_CELL = {1'b1, ALL_WALLS};

    typedef struct packed {
        logic       accept;
        logic       clr_step;
        logic       start;
        logic       pop;
        logic       load_cur;
        logic       rd_nb;
        logic [1:0] nb_k;
        logic       cap_cur;
        logic       cap_nb;
        logic [1:0] cap_k;
        logic       choose;
        logic       wr_cur;
        logic       wr_next;
        logic       read_cell;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic stack_empty;
        logic sweep_last;
        logic has_cand;
        logic out_free;
    } t_sts;

    function automatic logic [1:0] pick_mod(input logic [PICK_W-1:0] pick,
                                            input logic [2:0] cnt);
        logic [1:0] res;
        res = 2'd0;
        case (cnt)
            3'd2: res = {1'b0, pick[0]};
            3'd3: begin
                if (pick inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15}) res = 2'd0;
                else if (pick inside {4'd1, 4'd4, 4'd7, 4'd10, 4'd13}) res = 2'd1;
                else res = 2'd2;
            end
            3'd4: res = pick[1:0];
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] nth_set(input logic [3:0] cand, input logic [1:0] n);
        logic [2:0] seen;
        logic [1:0] res;
        seen = 3'd0;
        res  = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand[k]) begin
                if (seen == {1'b0, n}) res = 2'(k);
                seen = seen + 3'd1;
            end
        end
        return res;
    endfunction

    function automatic logic [1:0] dir_of(input logic [1:0] k);
        logic [1:0] res;
        case (k)
            NB_S:    res = DIR_S;
            NB_E:    res = DIR_E;
            NB_N:    res = DIR_N;
            default: res = DIR_W;
        endcase
        return res;
    endfunction

endpackage

// File: src/dfs_maze_carver.sv
// top level of the depth-first maze carver: controller plus datapath
// step: pop, read the cell and its four neighbours, pick, and on a carve write both cells;
//   an empty stack goes straight to the result; read: one cell; start: sweep the store first
// throughput: one transaction at a time, as input ready is high only while idle; the neighbour scan
//   and wall updates go through the cell store's one read and one write port one cell per cycle
// reset: synchronous active low; afterwards every cell of the store is swept one cell per cycle
//   with input ready low, config writes still taken
module dfs_maze_carver
    import dmc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_op,
    input  logic [COORD_W-1:0]   i_cell_col,
    input  logic [COORD_W-1:0]   i_cell_row,
    input  logic [PICK_W-1:0]    i_pick,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COORD_W-1:0]   o_cur_col,
    output logic [COORD_W-1:0]   o_cur_row,
    output logic                 o_carved,
    output logic [1:0]           o_carve_dir,
    output logic [COORD_W-1:0]   o_next_col,
    output logic [COORD_W-1:0]   o_next_row,
    output logic                 o_done_res,
    output logic [WALL_W-1:0]    o_wall_mask
);

    t_cmd cmd;
    t_sts sts;

    dmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    dmc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_pick      (i_pick),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cur_col   (o_cur_col),
        .o_cur_row   (o_cur_row),
        .o_carved    (o_carved),
        .o_carve_dir (o_carve_dir),
        .o_next_col  (o_next_col),
        .o_next_row  (o_next_row),
        .o_done_res  (o_done_res),
        .o_wall_mask (o_wall_mask)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready high right after an accepted transaction");

    a_carve_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_carved) |-> !o_done_res)
        else $error("carving step reports an empty stack");

    a_no_carve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_carved) |->
            (o_carve_dir == DIR_N && o_next_col == '0 && o_next_row == '0))
        else $error("carve fields set without a carve");

    a_carve_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_carved) |->
            ((o_carve_dir == DIR_N && o_next_row + 5'd1 == o_cur_row
                && o_next_col == o_cur_col) ||
             (o_carve_dir == DIR_S && o_cur_row + 5'd1 == o_next_row
                && o_next_col == o_cur_col) ||
             (o_carve_dir == DIR_E && o_cur_col + 5'd1 == o_next_col
                && o_next_row == o_cur_row) ||
             (o_carve_dir == DIR_W && o_next_col + 5'd1 == o_cur_col
                && o_next_row == o_cur_row)))
        else $error("carved cell is not adjacent in the carve direction");

    a_step_walls_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_carved) |-> (o_wall_mask == '0))
        else $error("carving step reports a wall mask");
`endif

endmodule

// File: src/dmc_ctrl.sv
// controller state machine sequencing clear, start, carve step and read transactions
module dmc_ctrl
    import dmc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    input  t_sts            i_sts,
    output logic            o_in_ready,
    output t_cmd            o_cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SWEEP, S_START, S_POP, S_LDCUR, S_RD_S, S_RD_E,
        S_RD_N, S_RD_W, S_RD_LAST, S_PICK, S_WR_CUR, S_WR_NXT, S_READ, S_RES
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            case (r_state)
                S_INIT:    if (i_sts.sweep_last) r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_op)
                            OP_START: r_state <= S_SWEEP;
                            OP_STEP:  r_state <= i_sts.stack_empty ? S_RES : S_POP;
                            OP_READ:  r_state <= S_READ;
                            default:  r_state <= S_RES;
                        endcase
                    end
                end
                S_SWEEP:   if (i_sts.sweep_last) r_state <= S_START;
                S_START:   r_state <= S_RES;
                S_POP:     r_state <= S_LDCUR;
                S_LDCUR:   r_state <= S_RD_S;
                S_RD_S:    r_state <= S_RD_E;
                S_RD_E:    r_state <= S_RD_N;
                S_RD_N:    r_state <= S_RD_W;
                S_RD_W:    r_state <= S_RD_LAST;
                S_RD_LAST: r_state <= S_PICK;
                S_PICK:    r_state <= i_sts.has_cand ? S_WR_CUR : S_RES;
                S_WR_CUR:  r_state <= S_WR_NXT;
                S_WR_NXT:  r_state <= S_RES;
                S_READ:    r_state <= S_RES;
                S_RES:     if (i_sts.out_free) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clr_step  = (r_state == S_INIT) || (r_state == S_SWEEP);
        o_cmd.start     = (r_state == S_START);
        o_cmd.pop       = (r_state == S_POP);
        o_cmd.load_cur  = (r_state == S_LDCUR);
        o_cmd.choose    = (r_state == S_PICK);
        o_cmd.wr_cur    = (r_state == S_WR_CUR);
        o_cmd.wr_next   = (r_state == S_WR_NXT);
        o_cmd.read_cell = (r_state == S_READ);
        o_cmd.out_load  = (r_state == S_RES) && i_sts.out_free;
        o_cmd.cap_cur   = (r_state == S_RD_S);
        case (r_state)
            S_RD_S: begin
                o_cmd.rd_nb = 1'b1;
                o_cmd.nb_k  = NB_S;
            end
            S_RD_E: begin
                o_cmd.rd_nb  = 1'b1;
                o_cmd.nb_k   = NB_E;
                o_cmd.cap_nb = 1'b1;
                o_cmd.cap_k  = NB_S;
            end
            S_RD_N: begin
                o_cmd.rd_nb  = 1'b1;
                o_cmd.nb_k   = NB_N;
                o_cmd.cap_nb = 1'b1;
                o_cmd.cap_k  = NB_E;
            end
            S_RD_W: begin
                o_cmd.rd_nb  = 1'b1;
                o_cmd.nb_k   = NB_W;
                o_cmd.cap_nb = 1'b1;
                o_cmd.cap_k  = NB_N;
            end
            S_RD_LAST: begin
                o_cmd.cap_nb = 1'b1;
                o_cmd.cap_k  = NB_W;
            end
            default: begin
                o_cmd.rd_nb = 1'b0;
            end
        endcase
    end

endmodule

// File: src/dmc_datapath.sv
// datapath: cell store, visit stack, neighbour scan, choice and result register
module dmc_datapath
    import dmc_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [OP_W-1:0]      i_op,
    input  logic [COORD_W-1:0]   i_cell_col,
    input  logic [COORD_W-1:0]   i_cell_row,
    input  logic [PICK_W-1:0]    i_pick,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [COORD_W-1:0]   o_cur_col,
    output logic [COORD_W-1:0]   o_cur_row,
    output logic                 o_carved,
    output logic [1:0]           o_carve_dir,
    output logic [COORD_W-1:0]   o_next_col,
    output logic [COORD_W-1:0]   o_next_row,
    output logic                 o_done_res,
    output logic [WALL_W-1:0]    o_wall_mask
);

    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int AW     = CW + RW;
    localparam int NSTORE = 1 << AW;
    localparam int NCELLS = MAX_COLS * MAX_ROWS;
    localparam int SAW    = $clog2(NCELLS);
    localparam int DW     = $clog2(NCELLS + 1);

    logic [CFG_W-1:0]   r_cols, r_rows, cols_used, rows_used;
    logic [OP_W-1:0]    r_op;
    logic [COORD_W-1:0] r_in_col, r_in_row;
    logic [PICK_W-1:0]  r_pick;

    logic [CW-1:0]      r_cur_col, r_next_col, start_col;
    logic [RW-1:0]      r_cur_row, r_next_row, start_row;
    logic [CFG_W-1:0]   sat_col, sat_row;
    logic [DW-1:0]      r_depth, depth_m1;
    logic [AW-1:0]      r_clr;

    logic [CELL_W-1:0]  r_cells [NSTORE];
    logic [CELL_W-1:0]  r_rd_q;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CELL_W-1:0]  wr_data;

    logic [AW-1:0]      r_stack [NCELLS];
    logic [AW-1:0]      r_stk_q;
    logic               push_en;
    logic [SAW-1:0]     push_idx;
    logic [AW-1:0]      push_data;

    logic [3:0]         r_cand;
    logic [WALL_W-1:0]  r_nbw [4];
    logic [WALL_W-1:0]  r_cur_walls;
    logic [1:0]         r_sel, sel_k, cur_dir, opp_dir;
    logic               r_carved;
    logic [2:0]         cand_cnt;

    logic [CW-1:0]      nb_col [4];
    logic [RW-1:0]      nb_row [4];
    logic [CW:0]        col_p1;
    logic [RW:0]        row_p1;
    logic               col_in, row_in, in_range;
    logic [3:0]         inb;
    logic               r_out_valid;

    // configuration registers and the bounds in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                default:  r_cols <= r_cols;
            endcase
        end
    end

    always_comb begin
        if (r_cols == '0)          cols_used = CFG_W'(1);
        else if (r_cols > MAX_COLS) cols_used = CFG_W'(MAX_COLS);
        else                       cols_used = r_cols;
        if (r_rows == '0)          rows_used = CFG_W'(1);
        else if (r_rows > MAX_ROWS) rows_used = CFG_W'(MAX_ROWS);
        else                       rows_used = r_rows;
    end

    // start cell saturates to the last column and row in use
    always_comb begin
        sat_col   = ({1'b0, r_in_col} >= cols_used) ? cols_used - CFG_W'(1) : {1'b0, r_in_col};
        sat_row   = ({1'b0, r_in_row} >= rows_used) ? rows_used - CFG_W'(1) : {1'b0, r_in_row};
        start_col = CW'(sat_col);
        start_row = RW'(sat_row);
        in_range  = (r_in_col < MAX_COLS) && (r_in_row < MAX_ROWS);
    end

    // neighbour coordinates in scan order and their bound checks
    always_comb begin
        nb_col[NB_S] = r_cur_col;
        nb_row[NB_S] = r_cur_row + RW'(1);
        nb_col[NB_E] = r_cur_col + CW'(1);
        nb_row[NB_E] = r_cur_row;
        nb_col[NB_N] = r_cur_col;
        nb_row[NB_N] = r_cur_row - RW'(1);
        nb_col[NB_W] = r_cur_col - CW'(1);
        nb_row[NB_W] = r_cur_row;
        col_p1 = {1'b0, r_cur_col} + (CW+1)'(1);
        row_p1 = {1'b0, r_cur_row} + (RW+1)'(1);
        col_in = r_cur_col < cols_used;
        row_in = r_cur_row < rows_used;
        inb[NB_S] = (row_p1 < rows_used) && col_in;
        inb[NB_E] = (col_p1 < cols_used) && row_in;
        inb[NB_N] = (r_cur_row != '0) && (r_cur_row <= rows_used) && col_in;
        inb[NB_W] = (r_cur_col != '0) && (r_cur_col <= cols_used) && row_in;
    end

    always_comb begin
        cand_cnt = 3'($countones(r_cand));
        sel_k    = nth_set(r_cand, pick_mod(r_pick, cand_cnt));
        cur_dir  = dir_of(r_sel);
        opp_dir  = cur_dir + 2'd2;
        depth_m1 = r_depth - DW'(1);
    end

    // cell store ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = CLR_CELL;
        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.start) begin
            wr_en   = 1'b1;
            wr_addr = {start_row, start_col};
            wr_data = START_CELL;
        end else if (i_cmd.wr_cur) begin
            wr_en   = 1'b1;
            wr_addr = {r_cur_row, r_cur_col};
            wr_data = {1'b1, r_cur_walls & ~(4'b1 << cur_dir)};
        end else if (i_cmd.wr_next) begin
            wr_en   = 1'b1;
            wr_addr = {r_next_row, r_next_col};
            wr_data = {1'b1, r_nbw[r_sel] & ~(4'b1 << opp_dir)};
        end
        rd_en = i_cmd.load_cur || i_cmd.rd_nb || i_cmd.read_cell;
        if (i_cmd.load_cur)   rd_addr = r_stk_q;
        else if (i_cmd.rd_nb) rd_addr = {nb_row[i_cmd.nb_k], nb_col[i_cmd.nb_k]};
        else                  rd_addr = {RW'(r_in_row), CW'(r_in_col)};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_cells[wr_addr] <= wr_data;
        if (rd_en) r_rd_q <= r_cells[rd_addr];
    end

    // visit stack ports
    always_comb begin
        push_en   = i_cmd.start || ((i_cmd.wr_cur || i_cmd.wr_next) && (r_depth < NCELLS));
        push_idx  = i_cmd.start ? '0 : r_depth[SAW-1:0];
        if (i_cmd.start)       push_data = {start_row, start_col};
        else if (i_cmd.wr_cur) push_data = {r_cur_row, r_cur_col};
        else                   push_data = {r_next_row, r_next_col};
    end

    always_ff @(posedge i_clk) begin
        if (push_en) r_stack[push_idx] <= push_data;
        if (i_cmd.pop) r_stk_q <= r_stack[depth_m1[SAW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_clr       <= '0;
            r_carved    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start)    r_depth <= DW'(1);
            else if (i_cmd.pop) r_depth <= depth_m1;
            else if ((i_cmd.wr_cur || i_cmd.wr_next) && (r_depth < NCELLS))
                r_depth <= r_depth + DW'(1);

            if (i_cmd.accept)        r_clr <= '0;
            else if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);

            if (i_cmd.accept) r_carved <= 1'b0;
            else if (i_cmd.choose && (cand_cnt != 3'd0)) r_carved <= 1'b1;

            if (i_cmd.out_load)  r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // transaction payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_op;
            r_in_col  <= i_cell_col;
            r_in_row  <= i_cell_row;
            r_pick    <= i_pick;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_sel     <= '0;
        end
        if (i_cmd.start) begin
            r_cur_col <= start_col;
            r_cur_row <= start_row;
        end
        if (i_cmd.load_cur) begin
            r_cur_col <= r_stk_q[CW-1:0];
            r_cur_row <= r_stk_q[AW-1:CW];
        end
        if (i_cmd.cap_cur) r_cur_walls <= r_rd_q[WALL_W-1:0];
        if (i_cmd.cap_nb) begin
            r_cand[i_cmd.cap_k] <= inb[i_cmd.cap_k] && !r_rd_q[VIS_BIT];
            r_nbw[i_cmd.cap_k]  <= r_rd_q[WALL_W-1:0];
        end
        if (i_cmd.choose && (cand_cnt != 3'd0)) begin
            r_sel      <= sel_k;
            r_next_col <= nb_col[sel_k];
            r_next_row <= nb_row[sel_k];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_cur_col   <= (r_op == OP_READ) ? r_in_col : COORD_W'(r_cur_col);
            o_cur_row   <= (r_op == OP_READ) ? r_in_row : COORD_W'(r_cur_row);
            o_carved    <= r_carved;
            o_carve_dir <= r_carved ? cur_dir : DIR_N;
            o_next_col  <= r_carved ? COORD_W'(r_next_col) : '0;
            o_next_row  <= r_carved ? COORD_W'(r_next_row) : '0;
            o_done_res  <= (r_depth == '0);
            case (r_op)
                OP_START: o_wall_mask <= ALL_WALLS;
                OP_READ:  o_wall_mask <= in_range ? r_rd_q[WALL_W-1:0] : '0;
                default:  o_wall_mask <= '0;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.sweep_last  = &r_clr;
    assign o_sts.has_cand    = (cand_cnt != 3'd0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

endmodule
